/* src/sst_pkg.sv */
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants of the speech segment tracker
// Sample widths, register map, configuration bundle, result record and the
// saturating helpers used by the segment logic.
// ----------------------------------------------------------------------------
package sst_pkg;

  // audio samples covered by one probability window
  localparam int unsigned WINDOW_SAMPLES = 512;

  localparam int SAMPLE_W  = 31;
  localparam int PROB_W    = 16;
  localparam int PAD_W     = 30;
  localparam int REG_IDX_W = 3;
  localparam int APB_AW    = REG_IDX_W + 2;
  localparam int APB_DW    = 32;

  // result queue: room for two results per request plus drain slack
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  typedef logic [SAMPLE_W-1:0]        sample_t;
  typedef logic signed [SAMPLE_W+1:0] wide_t;
  typedef logic [PROB_W-1:0]          prob_t;
  typedef logic [PAD_W-1:0]           pad_t;

  localparam sample_t WINDOW_STEP = sample_t'(WINDOW_SAMPLES);

  typedef enum logic {
    OP_WINDOW = 1'b0,
    OP_EOS    = 1'b1
  } op_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SPEECH_THR      = 3'd0,
    REG_SILENCE_THR     = 3'd1,
    REG_MIN_SILENCE     = 3'd2,
    REG_MIN_CUT_SILENCE = 3'd3,
    REG_MIN_SEGMENT     = 3'd4,
    REG_MAX_SEGMENT     = 3'd5,
    REG_PAD             = 3'd6,
    REG_CUT_LONGEST     = 3'd7
  } reg_idx_t;

  localparam prob_t   RST_SPEECH_THR      = prob_t'(32768);
  localparam prob_t   RST_SILENCE_THR     = prob_t'(22938);
  localparam sample_t RST_MIN_SILENCE     = sample_t'(1600);
  localparam sample_t RST_MIN_CUT_SILENCE = sample_t'(1568);
  localparam sample_t RST_MIN_SEGMENT     = sample_t'(4000);
  localparam sample_t RST_MAX_SEGMENT     = '1;
  localparam pad_t    RST_PAD             = pad_t'(480);
  localparam logic    RST_CUT_LONGEST     = 1'b1;

  typedef struct packed {
    prob_t   speech_thr;
    prob_t   silence_thr;
    sample_t min_silence_len;
    sample_t min_cut_silence_len;
    sample_t min_segment_len;
    sample_t max_segment_len;
    pad_t    pad_len;
    logic    cut_at_longest;
  } cfg_t;

  typedef struct packed {
    sample_t seg_start;
    sample_t seg_end;
    logic    last;
  } seg_t;

  // results handed to the queue in the same cycle, first then second
  typedef struct packed {
    logic [1:0] cnt;
    seg_t       first;
    seg_t       second;
  } push_t;

  function automatic wide_t widen(sample_t a);
    return wide_t'({2'b00, a});
  endfunction

  function automatic sample_t sat31(wide_t v);
    sample_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > widen('1)) begin
      r = '1;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

/* src/sst_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sst_cfg_regs: configuration register file
// APB-style write and read of the eight tracker settings.
// ----------------------------------------------------------------------------
module sst_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sst_pkg::APB_AW-1:0] paddr,
  input  logic [sst_pkg::APB_DW-1:0] pwdata,
  output logic [sst_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output sst_pkg::cfg_t             cfg
);
  import sst_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speech_thr          <= RST_SPEECH_THR;
      cfg_r.silence_thr         <= RST_SILENCE_THR;
      cfg_r.min_silence_len     <= RST_MIN_SILENCE;
      cfg_r.min_cut_silence_len <= RST_MIN_CUT_SILENCE;
      cfg_r.min_segment_len     <= RST_MIN_SEGMENT;
      cfg_r.max_segment_len     <= RST_MAX_SEGMENT;
      cfg_r.pad_len             <= RST_PAD;
      cfg_r.cut_at_longest      <= RST_CUT_LONGEST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SPEECH_THR:      cfg_r.speech_thr          <= pwdata[PROB_W-1:0];
        REG_SILENCE_THR:     cfg_r.silence_thr         <= pwdata[PROB_W-1:0];
        REG_MIN_SILENCE:     cfg_r.min_silence_len     <= pwdata[SAMPLE_W-1:0];
        REG_MIN_CUT_SILENCE: cfg_r.min_cut_silence_len <= pwdata[SAMPLE_W-1:0];
        REG_MIN_SEGMENT:     cfg_r.min_segment_len     <= pwdata[SAMPLE_W-1:0];
        REG_MAX_SEGMENT:     cfg_r.max_segment_len     <= pwdata[SAMPLE_W-1:0];
        REG_PAD:             cfg_r.pad_len             <= pwdata[PAD_W-1:0];
        REG_CUT_LONGEST:     cfg_r.cut_at_longest      <= pwdata[0];
        default:             cfg_r                     <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SPEECH_THR:      prdata = APB_DW'(cfg_r.speech_thr);
      REG_SILENCE_THR:     prdata = APB_DW'(cfg_r.silence_thr);
      REG_MIN_SILENCE:     prdata = APB_DW'(cfg_r.min_silence_len);
      REG_MIN_CUT_SILENCE: prdata = APB_DW'(cfg_r.min_cut_silence_len);
      REG_MIN_SEGMENT:     prdata = APB_DW'(cfg_r.min_segment_len);
      REG_MAX_SEGMENT:     prdata = APB_DW'(cfg_r.max_segment_len);
      REG_PAD:             prdata = APB_DW'(cfg_r.pad_len);
      REG_CUT_LONGEST:     prdata = APB_DW'(cfg_r.cut_at_longest);
      default:             prdata = '0;
    endcase
  end

endmodule

/* src/sst_core.sv */
// ----------------------------------------------------------------------------
// sst_core: segment tracking logic
// Input register, hysteresis state, max-length cuts, padding/merge hold and
// end-of-stream flush, each request resolved once the result queue has room.
// ----------------------------------------------------------------------------
module sst_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  sst_pkg::prob_t      in_prob,
  input  sst_pkg::sample_t    in_audio_length,
  input  sst_pkg::cfg_t       cfg,
  input  logic                space_ok,
  output sst_pkg::push_t      push
);
  import sst_pkg::*;

  typedef struct packed {
    logic    emit;
    sample_t emit_start;
    sample_t emit_end;
    sample_t new_start;
    sample_t new_end;
  } fin_t;

  // hand a finished raw segment to the hold: padding, half-gap merge
  function automatic fin_t do_finish(sample_t s_in, sample_t e_in, logic first,
                                     logic hv, sample_t hs, sample_t he, wide_t pad);
    fin_t  r;
    wide_t s;
    wide_t gap;
    wide_t half;
    wide_t hend;
    s    = widen(s_in);
    hend = '0;
    if (first) begin
      s = s - pad;
      if (s < 0) s = '0;
    end
    if (hv) begin
      gap  = s - widen(he);
      // half gap, truncated toward zero
      half = (gap + ((gap < 0) ? wide_t'(1) : wide_t'(0))) >>> 1;
      if (gap < (pad <<< 1)) begin
        hend = widen(he) + half;
        s    = s - half;
      end else begin
        hend = widen(he) + pad;
        s    = s - pad;
      end
      if (s < 0) s = '0;
    end
    r.emit       = hv;
    r.emit_start = hs;
    r.emit_end   = sat31(hend);
    r.new_start  = sat31(s);
    r.new_end    = e_in;
    return r;
  endfunction

  // request register
  logic    it_valid_r;
  op_t     it_op_r;
  prob_t   it_prob_r;
  sample_t it_alen_r;

  // tracker state; in_speech also stands for "open segment valid"
  sample_t sample_count_r, sample_count_nxt;
  logic    in_speech_r, in_speech_nxt;
  sample_t silence_begin_r, silence_begin_nxt;
  sample_t cut_point_r, cut_point_nxt;
  sample_t resume_point_r, resume_point_nxt;
  sample_t open_start_r, open_start_nxt;
  sample_t best_start_r, best_start_nxt;
  sample_t best_dur_r, best_dur_nxt;
  logic    best_valid_r, best_valid_nxt;
  sample_t held_start_r, held_start_nxt;
  sample_t held_end_r, held_end_nxt;
  logic    held_valid_r, held_valid_nxt;
  logic    first_pending_r, first_pending_nxt;

  logic    fire;
  logic    fin_req;
  logic    drop;
  sample_t fin_e;
  fin_t    fin;
  sample_t cur;
  sample_t now;
  sample_t sb_eff;
  wide_t   pad;
  wide_t   sd_a;
  wide_t   sd_c;
  wide_t   run_len;
  wide_t   eos_len;
  wide_t   tail_sum;
  logic    hv_after;
  sample_t hs_after;
  sample_t he_after;
  sample_t tail_end;

  assign fire     = it_valid_r && space_ok;
  assign in_ready = !it_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_valid_r <= 1'b0;
    end else if (in_ready) begin
      it_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      it_op_r   <= op_t'(in_op);
      it_prob_r <= in_prob;
      it_alen_r <= in_audio_length;
    end
  end

  assign cur     = sample_count_r;
  assign now     = sample_count_r + WINDOW_STEP;
  assign sb_eff  = (silence_begin_r == '0) ? cur : silence_begin_r;
  assign pad     = wide_t'({3'b000, cfg.pad_len});
  assign sd_a    = widen(cur) - widen(silence_begin_r);
  assign sd_c    = widen(cur) - widen(sb_eff);
  assign run_len = widen(now) - widen(open_start_r);
  assign eos_len = widen(it_alen_r) - widen(open_start_r);

  always_comb begin
    sample_count_nxt  = sample_count_r;
    in_speech_nxt     = in_speech_r;
    silence_begin_nxt = silence_begin_r;
    cut_point_nxt     = cut_point_r;
    resume_point_nxt  = resume_point_r;
    open_start_nxt    = open_start_r;
    best_start_nxt    = best_start_r;
    best_dur_nxt      = best_dur_r;
    best_valid_nxt    = best_valid_r;
    held_start_nxt    = held_start_r;
    held_end_nxt      = held_end_r;
    held_valid_nxt    = held_valid_r;
    first_pending_nxt = first_pending_r;
    fin_req           = 1'b0;
    fin_e             = '0;
    drop              = 1'b0;
    push              = '0;

    if (fire) begin
      if (it_op_r == OP_EOS) begin
        // flush the open segment if long enough
        if (in_speech_r && (eos_len > widen(cfg.min_segment_len))) begin
          fin_req = 1'b1;
          fin_e   = it_alen_r;
        end
      end else begin
        sample_count_nxt = now;
        priority if (it_prob_r >= cfg.speech_thr) begin
          if (silence_begin_r != '0) begin
            if ((sd_a > widen(cfg.min_cut_silence_len)) &&
                (!best_valid_r || (sd_a > widen(best_dur_r)))) begin
              best_start_nxt = silence_begin_r;
              best_dur_nxt   = sd_a[SAMPLE_W-1:0];
              best_valid_nxt = 1'b1;
            end
            silence_begin_nxt = '0;
            if (resume_point_r < cut_point_r) resume_point_nxt = cur;
          end
          if (!in_speech_r) begin
            in_speech_nxt  = 1'b1;
            open_start_nxt = cur;
          end
        end else if (in_speech_r && (run_len > widen(cfg.max_segment_len))) begin
          // segment too long: cut it
          fin_req = 1'b1;
          drop    = 1'b1;
          if (cfg.cut_at_longest && best_valid_r) begin
            fin_e = best_start_r;
            if (best_dur_r < cur) begin
              open_start_nxt = best_start_r + best_dur_r;
            end else begin
              in_speech_nxt = 1'b0;
            end
          end else if (cut_point_r != '0) begin
            fin_e = cut_point_r;
            if (resume_point_r < cut_point_r) begin
              in_speech_nxt = 1'b0;
            end else begin
              open_start_nxt = resume_point_r;
            end
          end else begin
            fin_e         = now;
            in_speech_nxt = 1'b0;
          end
        end else if ((it_prob_r < cfg.silence_thr) && in_speech_r) begin
          silence_begin_nxt = sb_eff;
          if (!cfg.cut_at_longest && (sd_c > widen(cfg.min_cut_silence_len))) begin
            cut_point_nxt = sb_eff;
          end
          if ((sd_c >= widen(cfg.min_silence_len)) &&
              ((widen(sb_eff) - widen(open_start_r)) > widen(cfg.min_segment_len))) begin
            fin_req       = 1'b1;
            fin_e         = sb_eff;
            drop          = 1'b1;
            in_speech_nxt = 1'b0;
          end
        end else begin
          // neutral window: only the counter moves
          sample_count_nxt = now;
        end
      end
    end

    fin = do_finish(open_start_r, fin_e, first_pending_r, held_valid_r,
                    held_start_r, held_end_r, pad);

    if (fin_req) begin
      held_start_nxt    = fin.new_start;
      held_end_nxt      = fin.new_end;
      held_valid_nxt    = 1'b1;
      first_pending_nxt = 1'b0;
    end

    if (drop) begin
      cut_point_nxt     = '0;
      resume_point_nxt  = '0;
      silence_begin_nxt = '0;
      best_valid_nxt    = 1'b0;
      best_start_nxt    = '0;
      best_dur_nxt      = '0;
    end

    // end of stream: tail of the hold, clamped to the audio length
    hv_after = held_valid_r || fin_req;
    hs_after = fin_req ? fin.new_start : held_start_r;
    he_after = fin_req ? fin.new_end : held_end_r;
    tail_sum = widen(he_after) + pad;
    tail_end = (tail_sum > widen(it_alen_r)) ? it_alen_r : tail_sum[SAMPLE_W-1:0];

    if (fire && (it_op_r == OP_EOS)) begin
      if (fin_req && fin.emit) begin
        push.cnt    = 2'd2;
        push.first  = '{seg_start: fin.emit_start, seg_end: fin.emit_end, last: 1'b0};
        push.second = '{seg_start: hs_after, seg_end: tail_end, last: 1'b1};
      end else if (hv_after) begin
        push.cnt   = 2'd1;
        push.first = '{seg_start: hs_after, seg_end: tail_end, last: 1'b1};
      end
      sample_count_nxt  = '0;
      in_speech_nxt     = 1'b0;
      silence_begin_nxt = '0;
      cut_point_nxt     = '0;
      resume_point_nxt  = '0;
      open_start_nxt    = '0;
      best_start_nxt    = '0;
      best_dur_nxt      = '0;
      best_valid_nxt    = 1'b0;
      held_start_nxt    = '0;
      held_end_nxt      = '0;
      held_valid_nxt    = 1'b0;
      first_pending_nxt = 1'b1;
    end else if (fin_req && fin.emit) begin
      push.cnt   = 2'd1;
      push.first = '{seg_start: fin.emit_start, seg_end: fin.emit_end, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r  <= '0;
      in_speech_r     <= 1'b0;
      silence_begin_r <= '0;
      cut_point_r     <= '0;
      resume_point_r  <= '0;
      open_start_r    <= '0;
      best_start_r    <= '0;
      best_dur_r      <= '0;
      best_valid_r    <= 1'b0;
      held_start_r    <= '0;
      held_end_r      <= '0;
      held_valid_r    <= 1'b0;
      first_pending_r <= 1'b1;
    end else begin
      sample_count_r  <= sample_count_nxt;
      in_speech_r     <= in_speech_nxt;
      silence_begin_r <= silence_begin_nxt;
      cut_point_r     <= cut_point_nxt;
      resume_point_r  <= resume_point_nxt;
      open_start_r    <= open_start_nxt;
      best_start_r    <= best_start_nxt;
      best_dur_r      <= best_dur_nxt;
      best_valid_r    <= best_valid_nxt;
      held_start_r    <= held_start_nxt;
      held_end_r      <= held_end_nxt;
      held_valid_r    <= held_valid_nxt;
      first_pending_r <= first_pending_nxt;
    end
  end

endmodule

/* src/sst_out_fifo.sv */
// ----------------------------------------------------------------------------
// sst_out_fifo: result queue
// Register queue taking up to two results per cycle, one out per ready cycle.
// ----------------------------------------------------------------------------
module sst_out_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  sst_pkg::push_t push,
  output logic           space_ok,
  output logic           out_valid,
  input  logic           out_ready,
  output sst_pkg::seg_t  out_seg
);
  import sst_pkg::*;

  seg_t              mem_r [OUT_DEPTH];
  logic [OUT_AW-1:0] head_r, head_nxt;
  logic [OUT_AW-1:0] tail_r, tail_nxt;
  logic [OUT_AW:0]   count_r, count_nxt;
  logic              pop;

  assign out_valid = (count_r != '0);
  assign out_seg   = mem_r[head_r];
  assign pop       = out_valid && out_ready;
  // room for a worst-case request of two results
  assign space_ok  = (count_r <= (OUT_AW+1)'(OUT_DEPTH - 2));

  assign head_nxt  = head_r + OUT_AW'(pop);
  assign tail_nxt  = tail_r + OUT_AW'(push.cnt);
  assign count_nxt = count_r + (OUT_AW+1)'(push.cnt) - (OUT_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[tail_r] <= push.first;
    if (push.cnt == 2'd2) mem_r[tail_r + OUT_AW'(1)] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* src/speech_segment_tracker.sv */
// ----------------------------------------------------------------------------
// speech_segment_tracker: voice activity hysteresis segmenter
// Turns a stream of per-window speech probabilities into padded, merged
// speech segments, with max-length cutting and end-of-stream flush.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  --------  -------------------  ------------------------------------------
//  in        in_valid/in_ready    in_op, in_prob, in_audio_length
//  out       out_valid/out_ready  out_seg_start, out_seg_end, out_last
//  cfg       psel/penable/pready  paddr, pwdata, pwrite, prdata
//
//  one request per cycle while the result queue has room: a request waits in
//  the input register until the queue has room and is resolved there; its
//  results enter the queue at the next edge and show on out right after it
//  throughput is bound by the result port: one result per cycle while
//  out_ready is high; an end of stream request gives up to two results
//  in_ready drops while the four-entry result queue has fewer than two free
//  slots and a request is waiting in the input register
//  rst_n is synchronous: it empties the queue and input register, restores
//  the register defaults and clears the tracker state
//  pready is tied high; writes land at the access cycle
//
module speech_segment_tracker (
  input  logic                      clk,
  input  logic                      rst_n,
  // request side
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_op,
  input  logic [15:0]               in_prob,
  input  logic [30:0]               in_audio_length,
  // result side
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [30:0]               out_seg_start,
  output logic [30:0]               out_seg_end,
  output logic                      out_last,
  // register port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sst_pkg::APB_AW-1:0] paddr,
  input  logic [sst_pkg::APB_DW-1:0] pwdata,
  output logic [sst_pkg::APB_DW-1:0] prdata,
  output logic                      pready
);
  import sst_pkg::*;

  cfg_t  cfg;
  push_t push;
  seg_t  out_seg;
  logic  space_ok;

  // settings; the user writes them only while the tracker is idle, the block does not enforce it
  sst_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // hysteresis, cutting and hold: one request resolved per cycle while the queue has room
  sst_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_prob         (in_prob),
    .in_audio_length (in_audio_length),
    .cfg             (cfg),
    .space_ok        (space_ok),
    .push            (push)
  );

  // result queue decouples the result port from the tracker
  sst_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_seg   (out_seg)
  );

  assign out_seg_start = out_seg.seg_start;
  assign out_seg_end   = out_seg.seg_end;
  assign out_last      = out_seg.last;

endmodule

/* src/sst_checker.sv */
// ----------------------------------------------------------------------------
// sst_checker: port-level checks of the speech segment tracker
// Result hold under stall, reset behavior and register defaults.
// ----------------------------------------------------------------------------
module sst_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [30:0]               out_seg_start,
  input logic [30:0]               out_seg_end,
  input logic                      out_last,
  input logic                      psel,
  input logic                      pwrite,
  input logic [sst_pkg::APB_AW-1:0] paddr,
  input logic [sst_pkg::APB_DW-1:0] prdata
);
  import sst_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_seg_start) &&
      $stable(out_seg_end) && $stable(out_last))
    else $error("stalled result changed");

  // reset empties the result queue
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // reset leaves the request side open
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("request side blocked after reset");

  // speech threshold reads back its default right after reset
  a_rst_default: assert property (@(posedge clk)
    $past(!rst_n) && psel && !pwrite && (paddr == APB_AW'(0)) |->
      prdata == APB_DW'(RST_SPEECH_THR))
    else $error("speech threshold default wrong");

endmodule

bind speech_segment_tracker sst_checker u_sst_checker (.*);

/* dv/segment_checker.sv */
// ----------------------------------------------------------------------------
// segment_checker: result checking for the speech segment tracker
// Follows the register writes and the tracker state, predicts the segments
// each request yields and compares them in order with the result channel.
// ----------------------------------------------------------------------------
module segment_checker
  import sst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_op,
  input  logic [15:0]       in_prob,
  input  logic [30:0]       in_audio_length,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [30:0]       out_seg_start,
  input  logic [30:0]       out_seg_end,
  input  logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int                mismatches,
  output int                segs_due
);

  // register copy
  prob_t   speech_thr, silence_thr;
  sample_t min_silence, min_cut_silence, min_segment, max_segment;
  pad_t    pad;
  logic    cut_longest;

  // tracker copy
  sample_t pos, quiet_from, cut_at, resume_at, open_start;
  sample_t best_from, best_len, held_start, held_end;
  logic    talking, open_valid, best_valid, held_valid, first_open;

  seg_t due_q[$];   // segments still to come, oldest first
  seg_t step_q[$];  // segments of the request being predicted
  int   errs = 0;

  function automatic longint num(sample_t v);
    return longint'({33'd0, v});
  endfunction

  function automatic longint pad_num();
    return longint'({34'd0, pad});
  endfunction

  function automatic sample_t clip(longint v);
    if (v < 0) return '0;
    if (v > num('1)) return '1;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic void forget_silences();
    cut_at = '0;
    resume_at = '0;
    quiet_from = '0;
    best_valid = 1'b0;
    best_from = '0;
    best_len = '0;
  endfunction

  function automatic void clear_tracker();
    forget_silences();
    pos = '0;
    open_start = '0;
    held_start = '0;
    held_end = '0;
    talking = 1'b0;
    open_valid = 1'b0;
    held_valid = 1'b0;
    first_open = 1'b1;
  endfunction

  // padding and half-gap merge through the one-segment hold
  function automatic void hold_segment(longint s, longint e);
    longint p, gap, hend;
    seg_t r;
    p = pad_num();
    if (first_open) begin
      s = s - p;
      if (s < 0) s = 0;
      first_open = 1'b0;
    end
    if (held_valid) begin
      gap = s - num(held_end);
      if (gap < 2 * p) begin
        hend = num(held_end) + gap / 2;
        s = s - gap / 2;
      end else begin
        hend = num(held_end) + p;
        s = s - p;
      end
      if (s < 0) s = 0;
      r.seg_start = held_start;
      r.seg_end = clip(hend);
      r.last = 1'b0;
      step_q = {step_q, r};
    end
    held_start = clip(s);
    held_end = clip(e);
    held_valid = 1'b1;
  endfunction

  function automatic void track_window(prob_t prob);
    longint cur, now, sd, bs, bd;
    cur = num(pos);
    pos = pos + WINDOW_STEP;
    now = num(pos);
    if (prob >= speech_thr) begin
      if (quiet_from != '0) begin
        sd = cur - num(quiet_from);
        if (sd > num(min_cut_silence) && (!best_valid || sd > num(best_len))) begin
          best_from = quiet_from;
          best_len = clip(sd);
          best_valid = 1'b1;
        end
        quiet_from = '0;
        if (resume_at < cut_at) resume_at = cur[SAMPLE_W-1:0];
      end
      if (!talking) begin
        talking = 1'b1;
        open_start = cur[SAMPLE_W-1:0];
        open_valid = 1'b1;
      end
    end else if (talking && (now - num(open_start)) > num(max_segment)) begin
      if (cut_longest && best_valid) begin
        bs = num(best_from);
        bd = num(best_len);
        hold_segment(num(open_start), bs);
        if (bd < cur) begin
          open_start = sample_t'(bs + bd);
          open_valid = 1'b1;
        end else begin
          talking = 1'b0;
          open_valid = 1'b0;
        end
      end else if (cut_at != '0) begin
        hold_segment(num(open_start), num(cut_at));
        if (resume_at < cut_at) begin
          talking = 1'b0;
          open_valid = 1'b0;
        end else begin
          open_start = resume_at;
          open_valid = 1'b1;
        end
      end else begin
        hold_segment(num(open_start), now);
        talking = 1'b0;
        open_valid = 1'b0;
      end
      forget_silences();
    end else if (prob < silence_thr && talking) begin
      if (quiet_from == '0) quiet_from = cur[SAMPLE_W-1:0];
      sd = cur - num(quiet_from);
      if (!cut_longest && sd > num(min_cut_silence)) cut_at = quiet_from;
      if (sd >= num(min_silence) && (num(quiet_from) - num(open_start)) > num(min_segment)) begin
        hold_segment(num(open_start), num(quiet_from));
        forget_silences();
        talking = 1'b0;
        open_valid = 1'b0;
      end
    end
  endfunction

  function automatic void close_stream(sample_t alen);
    longint e;
    seg_t r;
    if (open_valid && (num(alen) - num(open_start)) > num(min_segment))
      hold_segment(num(open_start), num(alen));
    if (held_valid) begin
      e = num(held_end) + pad_num();
      if (e > num(alen)) e = num(alen);
      r.seg_start = held_start;
      r.seg_end = clip(e);
      r.last = 1'b0;
      step_q = {step_q, r};
    end
    clear_tracker();
  endfunction

  always @(posedge clk) begin
    seg_t want;
    if (!rst_n) begin
      speech_thr = RST_SPEECH_THR;
      silence_thr = RST_SILENCE_THR;
      min_silence = RST_MIN_SILENCE;
      min_cut_silence = RST_MIN_CUT_SILENCE;
      min_segment = RST_MIN_SEGMENT;
      max_segment = RST_MAX_SEGMENT;
      pad = RST_PAD;
      cut_longest = RST_CUT_LONGEST;
      clear_tracker();
      due_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_AW-1:2]))
          REG_SPEECH_THR:      speech_thr = pwdata[PROB_W-1:0];
          REG_SILENCE_THR:     silence_thr = pwdata[PROB_W-1:0];
          REG_MIN_SILENCE:     min_silence = pwdata[SAMPLE_W-1:0];
          REG_MIN_CUT_SILENCE: min_cut_silence = pwdata[SAMPLE_W-1:0];
          REG_MIN_SEGMENT:     min_segment = pwdata[SAMPLE_W-1:0];
          REG_MAX_SEGMENT:     max_segment = pwdata[SAMPLE_W-1:0];
          REG_PAD:             pad = pwdata[PAD_W-1:0];
          REG_CUT_LONGEST:     cut_longest = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        step_q.delete();
        if (in_op == OP_EOS) close_stream(in_audio_length);
        else track_window(in_prob);
        // the last segment of a request carries the last flag
        if (step_q.size() > 0) begin
          want = step_q.pop_back();
          want.last = 1'b1;
          step_q = {step_q, want};
        end
        due_q = {due_q, step_q};
        step_q.delete();
      end
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          $error("segment with none due: seg_start %0d seg_end %0d last %0d",
                 out_seg_start, out_seg_end, out_last);
          errs++;
        end else begin
          want = due_q.pop_front();
          if (out_seg_start !== want.seg_start) begin
            $error("seg_start: expected %0d, actual %0d", want.seg_start, out_seg_start);
            errs++;
          end
          if (out_seg_end !== want.seg_end) begin
            $error("seg_end: expected %0d, actual %0d", want.seg_end, out_seg_end);
            errs++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_last);
            errs++;
          end
        end
      end
    end
    mismatches <= errs;
    segs_due <= due_q.size();
  end

endmodule

/* dv/speech_segment_tracker_tb.sv */
// ----------------------------------------------------------------------------
// speech_segment_tracker_tb: regression for the speech segment tracker
// Feeds window and end-of-stream requests under several register settings,
// with random idling on both channels; segment_checker predicts and compares
// every segment, and this module gives the verdict.
// ----------------------------------------------------------------------------
module speech_segment_tracker_tb;
  import sst_pkg::*;

  // cycles without any handshake before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // leave a little slack for windows in flight
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;

  typedef enum {P_SPEECH, P_SILENCE, P_MID, P_ANY} level_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_op = OP_WINDOW;
  logic [15:0]       in_prob = '0;
  logic [30:0]       in_audio_length = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [30:0]       out_seg_start;
  logic [30:0]       out_seg_end;
  logic              out_last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int mismatches;
  int segs_due;

  // no idling on either side while set
  logic calm = 1'b0;

  // settings in force, used to shape the probabilities and run lengths
  prob_t   speech_now, silence_now;
  sample_t min_silence_now, min_segment_now;

  int sent = 0;        // requests accepted so far
  int stream_pos = 0;  // samples covered since the last end of stream
  int idle_cycles = 0;

  speech_segment_tracker dut (.*);
  segment_checker seg_chk (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side stalls at random, with a chance of about 9 in a hundred
  always @(posedge clk) out_ready <= calm || ($urandom_range(0, 99) >= 9);

  // watchdog: a request or result handshake or a register write restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("speech_segment_tracker regression: fail");
      $finish;
    end
  end

  // setup phase, access phase, then a quiet phase so writes never overlap
  task automatic reg_write(reg_idx_t idx, logic [APB_DW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // hold requests off until every segment has come out and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (segs_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(prob_t sp, prob_t si, sample_t msil, sample_t mcut,
                               sample_t mseg, sample_t maxseg, pad_t pd, logic longest);
    settle();
    reg_write(REG_SPEECH_THR, APB_DW'(sp));
    reg_write(REG_SILENCE_THR, APB_DW'(si));
    reg_write(REG_MIN_SILENCE, APB_DW'(msil));
    reg_write(REG_MIN_CUT_SILENCE, APB_DW'(mcut));
    reg_write(REG_MIN_SEGMENT, APB_DW'(mseg));
    reg_write(REG_MAX_SEGMENT, APB_DW'(maxseg));
    reg_write(REG_PAD, APB_DW'(pd));
    reg_write(REG_CUT_LONGEST, APB_DW'(longest));
    speech_now = sp;
    silence_now = si;
    min_silence_now = msil;
    min_segment_now = mseg;
  endtask

  // one request; valid stays up after acceptance so the next one can follow
  // at once, or drops for a random gap before about 9 requests in a hundred
  task automatic send_request(op_t op, prob_t prob, sample_t alen);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(0, 99) < 9) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_prob <= prob;
    in_audio_length <= alen;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  function automatic prob_t pick_prob(level_t lvl);
    int sp, si;
    sp = speech_now;
    si = silence_now;
    case (lvl)
      P_SPEECH:  return prob_t'($urandom_range(65535, sp));
      P_SILENCE: if (si > 0) return prob_t'($urandom_range(si - 1, 0));
      P_MID:     if (si < sp) return prob_t'($urandom_range(sp - 1, si));
      default: ;
    endcase
    return prob_t'($urandom);
  endfunction

  // windows spanning a length, capped so huge settings stay quick
  function automatic int windows_for(sample_t len);
    int w;
    w = int'(len / WINDOW_STEP);
    return (w > 24) ? 24 : w;
  endfunction

  // window requests carry a random audio length, which the block ignores
  task automatic send_window(level_t lvl);
    send_request(OP_WINDOW, pick_prob(lvl), sample_t'($urandom));
    stream_pos += WINDOW_SAMPLES;
  endtask

  // audio length half the time near the samples sent, else zero, the largest or a random one
  task automatic end_stream();
    int alen;
    case ($urandom_range(0, 5))
      0: alen = 0;
      1: alen = int'(RST_MAX_SEGMENT);
      2: alen = int'($urandom_range(32'h7fff_ffff, 0));
      default: begin
        alen = stream_pos + int'($urandom_range(1023, 0)) - 512;
        if (alen < 0) alen = 0;
      end
    endcase
    send_request(OP_EOS, prob_t'($urandom), sample_t'(alen));
    stream_pos = 0;
  endtask

  // well-formed talk spurt: speech with short pauses, then a closing silence
  task automatic utterance();
    int talk_w, hush_w;
    talk_w = windows_for(min_segment_now) + 4;
    hush_w = windows_for(min_silence_now) + 2;
    repeat ($urandom_range(talk_w, 1)) begin
      send_window(($urandom_range(0, 9) == 0) ? P_MID : P_SPEECH);
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(hush_w, 1)) send_window(P_SILENCE);
    end
    repeat ($urandom_range(hush_w + 1, 1))
      send_window(($urandom_range(0, 7) == 0) ? P_MID : P_SILENCE);
  endtask

  task automatic random_phase(int items);
    int stop;
    stop = sent + items;
    while (sent < stop) begin
      case ($urandom_range(0, 19))
        0, 1: repeat ($urandom_range(6, 1)) send_window(P_ANY);   // noise
        2: end_stream();
        3: begin   // stream cut off in the middle of speech
          repeat ($urandom_range(5, 1)) send_window(P_SPEECH);
          end_stream();
        end
        default: utterance();
      endcase
    end
    end_stream();
  endtask

  task automatic random_settings_phase(int items);
    load_settings(prob_t'($urandom), prob_t'($urandom),
                  sample_t'($urandom_range(4000, 0)), sample_t'($urandom_range(4000, 0)),
                  sample_t'($urandom_range(6000, 0)), sample_t'($urandom_range(12000, 512)),
                  ($urandom_range(0, 3) == 0) ? pad_t'($urandom) : pad_t'($urandom_range(2000, 0)),
                  logic'($urandom_range(1, 0)));
    random_phase(items);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // short segments, hard cut at max length, first start clamped at zero,
    // exact thresholds, flush clamped to a zero audio length
    load_settings(16'd32768, 16'd22938, '0, '0, '0, 31'd1024, 30'd100, 1'b1);
    send_request(OP_WINDOW, 16'hffff, '0);
    send_request(OP_WINDOW, 16'h0000, '1);
    send_request(OP_WINDOW, 16'hffff, '0);
    send_request(OP_WINDOW, 16'd30000, '0);
    send_request(OP_WINDOW, 16'h0000, '0);
    send_request(OP_WINDOW, 16'd32768, '0);
    send_request(OP_WINDOW, 16'd22937, '0);
    send_request(OP_WINDOW, 16'd22938, '0);
    send_request(OP_EOS, 16'hffff, '0);

    // two equally long silences: the cut lands at the earlier one; the flush
    // then closes the rest at the largest audio length, giving two segments
    load_settings(16'd32768, 16'd22938, 31'd2048, '0, '0, 31'd3000, '0, 1'b1);
    send_request(OP_WINDOW, 16'hffff, '0);
    send_request(OP_WINDOW, 16'h0000, '0);
    send_request(OP_WINDOW, 16'h0000, '0);
    send_request(OP_WINDOW, 16'hffff, '0);
    send_request(OP_WINDOW, 16'h0000, '0);
    send_request(OP_WINDOW, 16'h0000, '0);
    send_request(OP_WINDOW, 16'hffff, '0);
    send_request(OP_WINDOW, 16'd30000, '0);
    send_request(OP_EOS, 16'h0000, '1);
    // end of stream with nothing open and nothing held
    send_request(OP_EOS, 16'h0000, 31'd12345);

    // legacy cut at the last valid silence, resuming where speech came back
    load_settings(16'd32768, 16'd22938, 31'd2048, '0, '0, 31'd3000, '0, 1'b0);
    send_request(OP_WINDOW, 16'hffff, '0);
    send_request(OP_WINDOW, 16'h0000, '0);
    send_request(OP_WINDOW, 16'h0000, '0);
    send_request(OP_WINDOW, 16'hffff, '0);
    send_request(OP_WINDOW, 16'd30000, '0);
    send_request(OP_WINDOW, 16'd30000, '0);
    send_request(OP_EOS, 16'h0000, 31'd5000);

    // reset values, written explicitly
    load_settings(RST_SPEECH_THR, RST_SILENCE_THR, RST_MIN_SILENCE, RST_MIN_CUT_SILENCE,
                  RST_MIN_SEGMENT, RST_MAX_SEGMENT, RST_PAD, RST_CUT_LONGEST);
    random_phase(200);

    // tight settings with frequent cuts at the longest silence, no idling
    load_settings(16'd40000, 16'd20000, 31'd1000, 31'd700, 31'd1500, 31'd6000,
                  30'd300, 1'b1);
    calm = 1'b1;
    random_phase(200);
    calm = 1'b0;

    // same lengths with the legacy cut
    load_settings(16'd40000, 16'd20000, 31'd1000, 31'd700, 31'd1500, 31'd6000,
                  30'd300, 1'b0);
    random_phase(200);

    // no cut candidates: every overlong segment is cut hard
    load_settings(16'd32768, 16'd30000, 31'd1500, '1, '0, 31'd1024, 30'd7, 1'b0);
    random_phase(150);

    // only full probability is speech, any other window during speech cuts; huge padding
    load_settings('1, '1, '0, '0, '0, '0, '1, 1'b1);
    random_phase(100);

    // everything speech, nothing long enough to keep
    load_settings('0, '0, '1, '1, '1, '1, '0, 1'b0);
    random_phase(40);

    random_settings_phase(180);
    random_settings_phase(180);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("speech_segment_tracker regression: pass");
    end else begin
      $display("speech_segment_tracker regression: fail");
    end
    $finish;
  end

endmodule
